// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the station record parser.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/srp_pkg.sv -----
// Package for the station record parser: character codes and widths.
// No dependencies.
package srp_pkg;

    localparam int NAME_COUNT_MAX = 255;
    localparam int NAME_COUNT_BITS = $clog2(NAME_COUNT_MAX + 1);
    // keep at least the 8 bits that the length port shows
    localparam int NAME_COUNT_W = (NAME_COUNT_BITS > 8) ? NAME_COUNT_BITS : 8;

    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int MAG_W   = 10;
    localparam int VALUE_W = 11;

    typedef logic [BYTE_W-1:0]       byte_t;
    typedef logic [DIGIT_W-1:0]      digit_t;
    typedef logic [NAME_COUNT_W-1:0] name_count_t;

    localparam byte_t CHAR_NEWLINE = 8'h0a;
    localparam byte_t CHAR_SEMI    = 8'h3b;
    localparam byte_t CHAR_MINUS   = 8'h2d;
    localparam byte_t CHAR_DOT     = 8'h2e;
    localparam byte_t CHAR_ZERO    = 8'h30;
    localparam byte_t CHAR_NINE    = 8'h39;

endpackage

// ----- rtl/station_record_parser.sv -----
// Station record parser: turns a name;value text stream into result words.
// A result word is valid in the cycle after its newline is accepted.
// Throughput: one byte per cycle; stall only while an untaken word fills the result register.
// Reset: aresetn (synchronous, active low) clears the record state and
// empties the result register; the block is ready in the first cycle after.
// Depends on srp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module station_record_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srp_pkg::byte_t      s_in_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output srp_pkg::byte_t      m_name_length,
    output srp_pkg::byte_t      m_name_byte_first,
    output srp_pkg::byte_t      m_name_byte_third,
    output srp_pkg::byte_t      m_name_byte_fifth,
    output srp_pkg::byte_t      m_name_byte_last,
    output logic signed [10:0]  m_value_tenths
);
    import srp_pkg::*;

    // Record state. The integer part lives as its last two digits, so a new
    // digit only shifts them along and no modulo is needed.
    logic        value_phase_reg, value_phase_next;
    name_count_t name_count_reg, name_count_next;
    byte_t       key_first_reg, key_first_next;
    byte_t       key_third_reg, key_third_next;
    byte_t       key_fifth_reg, key_fifth_next;
    byte_t       key_last_reg, key_last_next;
    logic        negative_reg, negative_next;
    digit_t      tens_reg, tens_next;
    digit_t      ones_reg, ones_next;
    digit_t      tenths_reg, tenths_next;
    logic        after_dot_reg, after_dot_next;

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    byte_t                    length_reg, length_next;
    byte_t                    first_reg, first_next;
    byte_t                    third_reg, third_next;
    byte_t                    fifth_reg, fifth_next;
    byte_t                    last_reg, last_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;

    logic                accept;
    logic                emit;
    logic                is_digit;
    digit_t              digit;
    logic [MAG_W-1:0]    magnitude;
    logic [VALUE_W-1:0]  mag_ext;
    logic                newline_in;
    logic                value_in_range;

    // Accept a byte whenever the result register is empty or is drained now.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_digit = (s_in_byte >= CHAR_ZERO) && (s_in_byte <= CHAR_NINE);
    assign digit    = DIGIT_W'(s_in_byte - CHAR_ZERO);

    // Value in tenths: tens*100 + ones*10 + tenths, at most 999.
    assign magnitude = MAG_W'(tens_reg) * MAG_W'(100)
                     + MAG_W'(ones_reg) * MAG_W'(10)
                     + MAG_W'(tenths_reg);
    assign mag_ext   = VALUE_W'(magnitude);

    always_comb begin
        value_phase_next = value_phase_reg;
        name_count_next  = name_count_reg;
        key_first_next   = key_first_reg;
        key_third_next   = key_third_reg;
        key_fifth_next   = key_fifth_reg;
        key_last_next    = key_last_reg;
        negative_next    = negative_reg;
        tens_next        = tens_reg;
        ones_next        = ones_reg;
        tenths_next      = tenths_reg;
        after_dot_next   = after_dot_reg;
        emit             = 1'b0;

        if (accept) begin
            if (!value_phase_reg) begin
                priority if (s_in_byte == CHAR_NEWLINE) begin
                    // newline inside the name: drop the partial record
                    name_count_next = '0;
                    key_first_next  = '0;
                    key_third_next  = '0;
                    key_fifth_next  = '0;
                    key_last_next   = '0;
                    negative_next   = 1'b0;
                    tens_next       = '0;
                    ones_next       = '0;
                    tenths_next     = '0;
                    after_dot_next  = 1'b0;
                end else if (s_in_byte == CHAR_SEMI) begin
                    value_phase_next = 1'b1;
                    negative_next    = 1'b0;
                    tens_next        = '0;
                    ones_next        = '0;
                    tenths_next      = '0;
                    after_dot_next   = 1'b0;
                end else begin
                    priority if (name_count_reg == '0) begin
                        key_first_next = s_in_byte;
                    end else if (name_count_reg == NAME_COUNT_W'(2)) begin
                        key_third_next = s_in_byte;
                    end else if (name_count_reg == NAME_COUNT_W'(4)) begin
                        key_fifth_next = s_in_byte;
                    end else begin
                    end
                    key_last_next = s_in_byte;
                    // saturate the name length
                    if (name_count_reg < NAME_COUNT_W'(NAME_COUNT_MAX)) begin
                        name_count_next = name_count_reg + NAME_COUNT_W'(1);
                    end
                end
            end else begin
                priority if (s_in_byte == CHAR_NEWLINE) begin
                    // end of record: emit and start a fresh one
                    emit             = 1'b1;
                    value_phase_next = 1'b0;
                    name_count_next  = '0;
                    key_first_next   = '0;
                    key_third_next   = '0;
                    key_fifth_next   = '0;
                    key_last_next    = '0;
                    negative_next    = 1'b0;
                    tens_next        = '0;
                    ones_next        = '0;
                    tenths_next      = '0;
                    after_dot_next   = 1'b0;
                end else if (s_in_byte == CHAR_MINUS) begin
                    negative_next = 1'b1;
                end else if (s_in_byte == CHAR_DOT) begin
                    after_dot_next = 1'b1;
                end else if (is_digit) begin
                    if (after_dot_reg) begin
                        tenths_next = digit;
                    end else begin
                        // keep only the last two integer digits
                        tens_next = ones_reg;
                        ones_next = digit;
                    end
                end else begin
                    // ignore any other byte in the value
                end
            end
        end

        // Result register: load on emit, clear once taken.
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        length_next = name_count_reg[7:0];
        first_next  = key_first_reg;
        third_next  = key_third_reg;
        fifth_next  = key_fifth_reg;
        last_next   = key_last_reg;
        value_next  = negative_reg ? $signed(VALUE_W'(-mag_ext)) : $signed(mag_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_phase_reg <= 1'b0;
            name_count_reg  <= '0;
            key_first_reg   <= '0;
            key_third_reg   <= '0;
            key_fifth_reg   <= '0;
            key_last_reg    <= '0;
            negative_reg    <= 1'b0;
            tens_reg        <= '0;
            ones_reg        <= '0;
            tenths_reg      <= '0;
            after_dot_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            value_phase_reg <= value_phase_next;
            name_count_reg  <= name_count_next;
            key_first_reg   <= key_first_next;
            key_third_reg   <= key_third_next;
            key_fifth_reg   <= key_fifth_next;
            key_last_reg    <= key_last_next;
            negative_reg    <= negative_next;
            tens_reg        <= tens_next;
            ones_reg        <= ones_next;
            tenths_reg      <= tenths_next;
            after_dot_reg   <= after_dot_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload holds until the next emit; no reset needed.
    always_ff @(posedge aclk) begin
        if (emit) begin
            length_reg <= length_next;
            first_reg  <= first_next;
            third_reg  <= third_next;
            fifth_reg  <= fifth_next;
            last_reg   <= last_next;
            value_reg  <= value_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_name_length     = length_reg;
    assign m_name_byte_first = first_reg;
    assign m_name_byte_third = third_reg;
    assign m_name_byte_fifth = fifth_reg;
    assign m_name_byte_last  = last_reg;
    assign m_value_tenths    = value_reg;

    assign newline_in     = accept && (s_in_byte == CHAR_NEWLINE);
    assign value_in_range = (value_reg >= -11'sd999) && (value_reg <= 11'sd999);

    // A newline that closes a value always leaves a word in the result register.
    `ASSERT_NEXT(a_emit_on_newline, aclk, aresetn, newline_in && value_phase_reg, m_valid_reg)
    // Any accepted newline starts a clean name.
    `ASSERT_NEXT(a_newline_clears, aclk, aresetn, newline_in, !value_phase_reg && ~|name_count_reg)
    // The emitted value stays within three decimal digits of tenths.
    `ASSERT_SAME(a_value_range, aclk, aresetn, m_valid_reg, value_in_range)

endmodule
